/* hdl/mf3_pkg.sv */
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants for the 3x3 median filter
// Payload structs, register indexes and frame-size limits.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;

  localparam int PIX_W    = 8;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int REG_IDX_W = 1;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(512);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(512);

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             flush;
  } in_data_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_data_t;

endpackage

/* hdl/median_filter_3x3_unit.sv */
// Latency: a pixel's result is computed when the item image_width+1 positions
//   later is accepted, and shows on out_data the cycle after that accept.
// Throughput: one item per cycle; a full output register only blocks input
//   while out_ready is low.
// Reset (sync, active low): counters, window and output valid clear; size
//   registers go to 512x512; the line memory is not cleared.
// ----------------------------------------------------------------------------
// median_filter_3x3_unit: streaming 3x3 median filter, 8-bit grayscale
// Two line buffers in one 1024x16 memory, a 3x2 column window and a
// 19-exchange median network feeding a single output register.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit
  import mf3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_data_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_data_t            out_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef logic [PIX_W-1:0] pix_t;

  function automatic pix_t med9(input pix_t a0, input pix_t a1, input pix_t a2,
                                input pix_t a3, input pix_t a4, input pix_t a5,
                                input pix_t a6, input pix_t a7, input pix_t a8);
    pix_t p [9];
    pix_t t;
    p[0] = a0; p[1] = a1; p[2] = a2; p[3] = a3; p[4] = a4;
    p[5] = a5; p[6] = a6; p[7] = a7; p[8] = a8;
    // fixed exchange network, min ends up at the first index of each pair
    if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
    if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
    if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
    if (p[0] > p[1]) begin t = p[0]; p[0] = p[1]; p[1] = t; end
    if (p[3] > p[4]) begin t = p[3]; p[3] = p[4]; p[4] = t; end
    if (p[6] > p[7]) begin t = p[6]; p[6] = p[7]; p[7] = t; end
    if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
    if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
    if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
    if (p[0] > p[3]) begin t = p[0]; p[0] = p[3]; p[3] = t; end
    if (p[5] > p[8]) begin t = p[5]; p[5] = p[8]; p[8] = t; end
    if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
    if (p[3] > p[6]) begin t = p[3]; p[3] = p[6]; p[6] = t; end
    if (p[1] > p[4]) begin t = p[1]; p[1] = p[4]; p[4] = t; end
    if (p[2] > p[5]) begin t = p[2]; p[2] = p[5]; p[5] = t; end
    if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
    if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
    if (p[6] > p[4]) begin t = p[6]; p[6] = p[4]; p[4] = t; end
    if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
    return p[4];
  endfunction

  // size registers hold clamped values
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  pix_t win_r [6];

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;
  logic [COL_W-1:0]   rd_addr;

  logic       out_valid_r;
  out_data_t  out_data_r;

  logic       acc;
  pix_t       pix, top, mid, val;
  logic       frame_end, has_result, use_median, row_wrap;
  logic [WIDTH_W-1:0]  wd_raw;
  logic [HEIGHT_W-1:0] ht_raw;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pix = in_data.flush ? '0 : in_data.pixel_in;
  assign top = rd_r[2*PIX_W-1:PIX_W];
  assign mid = rd_r[PIX_W-1:0];

  assign frame_end  = {1'b0, row_r} >= ({1'b0, ROW_W'(height_r)} + (ROW_W+1)'(1));
  assign has_result = (row_r >= ROW_W'(2)) || (row_r == ROW_W'(1) && col_r != '0);
  assign use_median = !frame_end
                      && ({1'b0, row_r} <= ({1'b0, ROW_W'(height_r)} - (ROW_W+1)'(1)))
                      && (col_r >= COL_W'(2))
                      && ({1'b0, col_r} <= (width_r - WIDTH_W'(1)));
  assign row_wrap   = ({1'b0, col_r} + WIDTH_W'(1)) >= width_r;

  always_comb begin
    val = win_r[1];
    if (use_median) begin
      val = med9(win_r[3], win_r[4], win_r[5], win_r[0], win_r[1], win_r[2],
                 top, mid, pix);
    end
  end

  // position of the next item
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  assign rd_addr = rst_n ? col_nxt : '0;

  always_ff @(posedge clk) begin
    if (acc) begin
      line_mem[col_r] <= {mid, pix};
    end
  end

  // prefetch for the next item; forward when it hits the entry just written
  always_ff @(posedge clk) begin
    if (acc && rd_addr == col_r) begin
      rd_r <= {mid, pix};
    end else begin
      rd_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (acc) begin
        win_r[3] <= win_r[0];
        win_r[4] <= win_r[1];
        win_r[5] <= win_r[2];
        win_r[0] <= top;
        win_r[1] <= mid;
        win_r[2] <= pix;
      end
    end
  end

  assign wd_raw = cfg_wdata[WIDTH_W-1:0];
  assign ht_raw = cfg_wdata[HEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (wd_raw < WIDTH_W'(MIN_SIZE))       width_r <= WIDTH_W'(MIN_SIZE);
          else if (wd_raw > WIDTH_W'(MAX_WIDTH)) width_r <= WIDTH_W'(MAX_WIDTH);
          else                                   width_r <= wd_raw;
        end
        REG_IMAGE_HEIGHT: begin
          if (ht_raw < HEIGHT_W'(MIN_SIZE))        height_r <= HEIGHT_W'(MIN_SIZE);
          else if (ht_raw > HEIGHT_W'(MAX_HEIGHT)) height_r <= HEIGHT_W'(MAX_HEIGHT);
          else                                     height_r <= ht_raw;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && has_result) begin
      out_data_r.pixel_out  <= val;
      out_data_r.frame_last <= frame_end;
    end
  end

endmodule

/* hdl/mf3_chk.sv */
// ----------------------------------------------------------------------------
// mf3_chk: port-level checks for the 3x3 median filter
// Output hold under stall, request blocking and reset behavior.
// ----------------------------------------------------------------------------
module mf3_chk
  import mf3_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_data_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // full output register that is not drained blocks new requests
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result register is blocked");

  // empty output register never blocks input
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind median_filter_3x3_unit mf3_chk u_mf3_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for median_filter_3x3_unit
// Streams frames (clamped oversize and undersize sizes, directed 3x3,
// mid-frame size changes, then random frames) through valid/ready with random
// idling on both sides. A local predictor works out each filtered pixel and
// the monitor compares every result in order, the pixel only where known.
// ----------------------------------------------------------------------------
module testbench;
  import mf3_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 300;
  localparam int MAX_REPORTS  = 20;

  typedef struct {
    out_data_t data;
    bit        pixel_known;  // 0: neighborhood held never-written line data
  } filtered_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_data_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_data_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  always #6 clk = ~clk;

  median_filter_3x3_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---- predictor state ----
  logic [WIDTH_W-1:0]  shadow_width;
  logic [HEIGHT_W-1:0] shadow_height;
  logic [PIX_W-1:0]    line_mem [2*MAX_WIDTH];
  bit                  line_known [2*MAX_WIDTH];
  logic [PIX_W-1:0]    win [6];
  bit                  win_known [6];
  int unsigned         row_pos, col_pos;

  in_data_t  pixel_stream [$];
  filtered_t expected_pixels [$];

  int items_queued, items_accepted, random_items;
  int results_seen, results_unchecked, frames_done;
  int error_count, reg_writes, midframe_changes;
  int quiet_cycles;
  bit calm;

  function automatic int unsigned eff_width();
    if (shadow_width < MIN_SIZE) return MIN_SIZE;
    if (shadow_width > MAX_WIDTH) return MAX_WIDTH;
    return shadow_width;
  endfunction

  function automatic int unsigned eff_height();
    if (shadow_height < MIN_SIZE) return MIN_SIZE;
    if (shadow_height > MAX_HEIGHT) return MAX_HEIGHT;
    return shadow_height;
  endfunction

  // steps a frame position; returns 1 when that position closes the frame
  function automatic bit advance_pos(inout int unsigned r, inout int unsigned c);
    if (r >= eff_height() + 1) begin
      r = 0;
      c = 0;
      return 1'b1;
    end
    if (c + 1 >= eff_width()) begin
      c = 0;
      r++;
    end else begin
      c++;
    end
    return 1'b0;
  endfunction

  function automatic void filter_reset();
    shadow_width  = RESET_WIDTH;
    shadow_height = RESET_HEIGHT;
    foreach (line_mem[i]) begin
      line_mem[i]   = '0;
      line_known[i] = 1'b0;
    end
    foreach (win[i]) begin
      win[i]       = '0;
      win_known[i] = 1'b1;
    end
    row_pos = 0;
    col_pos = 0;
  endfunction

  function automatic void filter_step(input in_data_t item);
    int unsigned      w, h, r, c, ci, j, k, cnt;
    logic [PIX_W-1:0] pix, top, mid, best;
    logic [PIX_W-1:0] nine [9];
    bit               nine_known [9];
    bit               top_known, mid_known, frame_end;
    filtered_t        res;
    w = eff_width();
    h = eff_height();
    pix = item.flush ? '0 : item.pixel_in;
    r = row_pos;
    c = col_pos;
    ci = c % MAX_WIDTH;
    top = line_mem[MAX_WIDTH + ci];
    top_known = line_known[MAX_WIDTH + ci];
    mid = line_mem[ci];
    mid_known = line_known[ci];
    frame_end = (r >= h + 1);
    if (r >= 2 || (r == 1 && c >= 1)) begin
      res.data.pixel_out = win[1];
      res.pixel_known = win_known[1];
      if (!frame_end && r <= h - 1 && c >= 2 && c <= w - 1) begin
        nine = '{win[0], win[1], win[2], win[3], win[4], win[5], top, mid, pix};
        nine_known = '{win_known[0], win_known[1], win_known[2], win_known[3],
                       win_known[4], win_known[5], top_known, mid_known, 1'b1};
        // median = smallest value with at least five entries at or below it
        best = '1;
        res.pixel_known = 1'b1;
        for (k = 0; k < 9; k++) begin
          cnt = 0;
          for (j = 0; j < 9; j++)
            if (nine[j] <= nine[k]) cnt++;
          if (cnt >= 5 && nine[k] < best) best = nine[k];
          res.pixel_known = res.pixel_known & nine_known[k];
        end
        res.data.pixel_out = best;
      end
      res.data.frame_last = frame_end;
      expected_pixels.push_back(res);
    end
    line_mem[MAX_WIDTH + ci]   = mid;
    line_known[MAX_WIDTH + ci] = mid_known;
    line_mem[ci]   = pix;
    line_known[ci] = 1'b1;
    for (k = 3; k < 6; k++) begin
      win[k]       = win[k-3];
      win_known[k] = win_known[k-3];
    end
    win[0] = top;
    win[1] = mid;
    win[2] = pix;
    win_known[0] = top_known;
    win_known[1] = mid_known;
    win_known[2] = 1'b1;
    void'(advance_pos(row_pos, col_pos));
  endfunction

  // ---- stimulus helpers ----
  task automatic push_item(input logic [PIX_W-1:0] pix, input logic flush);
    in_data_t it;
    it.pixel_in = pix;
    it.flush    = flush;
    pixel_stream.push_back(it);
    items_queued++;
  endtask

  function automatic int items_left_in_frame();
    int unsigned r, c;
    int n;
    r = row_pos;
    c = col_pos;
    n = 1;
    while (!advance_pos(r, c)) n++;
    return n;
  endfunction

  // fills count positions from the current frame position; noisy adds
  // stray flushes inside the image and pixels in the drain tail
  task automatic queue_frame_items(input int count, input bit noisy);
    int unsigned      r, c;
    bit               tail, flush;
    logic [PIX_W-1:0] pix;
    r = row_pos;
    c = col_pos;
    for (int i = 0; i < count; i++) begin
      tail = (r >= eff_height());
      pix = ($urandom_range(0, 4) == 0) ? {PIX_W{$urandom_range(0, 1) == 1}}
                                        : PIX_W'($urandom);
      flush = tail;
      if (noisy && tail && $urandom_range(0, 9) == 0) flush = 1'b0;
      if (noisy && !tail && $urandom_range(0, 39) == 0) flush = 1'b1;
      push_item(pix, flush);
      if (noisy) random_items++;
      void'(advance_pos(r, c));
    end
  endtask

  task automatic set_size_reg(input logic [REG_IDX_W-1:0] idx,
                              input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH)
      shadow_width = value[WIDTH_W-1:0];
    else
      shadow_height = value[HEIGHT_W-1:0];
    reg_writes++;
  endtask

  task automatic wait_idle();
    while (items_accepted != items_queued || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // ---- driver: request side ----
  int gap_left;
  bit send_idles = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        filter_step(in_data);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_stream.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pixel_stream.pop_front();
          if (!calm && send_idles && $urandom_range(0, 3) == 0)
            gap_left <= $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 149) == 0) send_idles <= ~send_idles;
    end
  end

  // ---- monitor: result side ----
  int        hold_left;
  bit        long_hold_done;
  bit        take_stalls = 1'b1;
  filtered_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result pixel=%0d last=%0b",
                                    out_data.pixel_out, out_data.frame_last));
        end else begin
          want = expected_pixels.pop_front();
          if (!want.pixel_known)
            results_unchecked++;
          else if (out_data.pixel_out !== want.data.pixel_out)
            report_mismatch($sformatf("result %0d pixel_out %0d, want %0d", results_seen,
                                      out_data.pixel_out, want.data.pixel_out));
          if (out_data.frame_last !== want.data.frame_last)
            report_mismatch($sformatf("result %0d frame_last %0b, want %0b", results_seen,
                                      out_data.frame_last, want.data.frame_last));
          if (want.data.frame_last) frames_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 200 && pixel_stream.size() >= 8) begin
        // long back-pressure so the block fills and drops in_ready
        long_hold_done <= 1'b1;
        hold_left <= 80;
        out_ready <= 1'b0;
      end else if (!calm && take_stalls && $urandom_range(0, 7) == 0) begin
        hold_left <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ($urandom_range(0, 149) == 0) take_stalls <= ~take_stalls;
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: %0d cycles without a request or result", quiet_cycles);
    $display("== FAIL ==");
    $finish;
  end

  // ---- sequence ----
  initial begin
    logic [PIX_W-1:0] d1 [9];
    logic [PIX_W-1:0] d2 [9];
    int n;
    d1 = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
    d2 = '{8'd10, 8'd200, 8'd30, 8'd0, 8'd128, 8'd250, 8'd1, 8'd254, 8'd77};
    filter_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all-ones writes clamp to the largest frame; a short stretch of the
    // widest row, then a narrow width mid-frame wraps the column at once
    set_size_reg(REG_IMAGE_WIDTH, '1);
    set_size_reg(REG_IMAGE_HEIGHT, '1);
    queue_frame_items(24, 1'b0);
    wait_idle();
    set_size_reg(REG_IMAGE_WIDTH, CFG_W'(4));
    set_size_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
    midframe_changes++;
    queue_frame_items(items_left_in_frame(), 1'b0);
    wait_idle();

    // directed 3x3: checkerboard of extremes, flushes carrying ignored data
    set_size_reg(REG_IMAGE_WIDTH, CFG_W'(3));
    set_size_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
    for (int i = 0; i < 9; i++) push_item(d1[i], 1'b0);
    repeat (4) push_item(8'hFF, 1'b1);
    // flush inside the image, pixels where flushes belong
    for (int i = 0; i < 9; i++) push_item(d2[i], i == 3);
    push_item(8'd255, 1'b0);
    push_item(8'd77, 1'b1);
    push_item(8'd0, 1'b0);
    push_item(8'd128, 1'b0);
    wait_idle();

    // height cut below the current row mid-frame: frame ends at once
    set_size_reg(REG_IMAGE_WIDTH, CFG_W'(5));
    set_size_reg(REG_IMAGE_HEIGHT, CFG_W'(8));
    queue_frame_items(37, 1'b0);
    wait_idle();
    set_size_reg(REG_IMAGE_HEIGHT, CFG_W'(4));
    midframe_changes++;
    queue_frame_items(items_left_in_frame(), 1'b0);
    wait_idle();

    // width cut below the current column mid-frame: column wraps
    set_size_reg(REG_IMAGE_WIDTH, CFG_W'(8));
    set_size_reg(REG_IMAGE_HEIGHT, CFG_W'(6));
    queue_frame_items(20, 1'b0);
    wait_idle();
    set_size_reg(REG_IMAGE_WIDTH, CFG_W'(3));
    midframe_changes++;
    queue_frame_items(items_left_in_frame(), 1'b0);
    wait_idle();

    // smallest frame from sizes below range (both clamp up)
    set_size_reg(REG_IMAGE_WIDTH, CFG_W'(2));
    set_size_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
    queue_frame_items(items_left_in_frame(), 1'b0);
    wait_idle();

    while (random_items < RANDOM_ITEMS) begin
      if (random_items > RANDOM_ITEMS - 100) calm = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        n = $urandom_range(0, 9);
        set_size_reg(REG_IMAGE_WIDTH, CFG_W'(n == 0 ? $urandom_range(0, 2) :
                                               n == 1 ? $urandom_range(13, 40) :
                                                        $urandom_range(3, 12)));
      end
      if ($urandom_range(0, 3) != 0)
        set_size_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 19) == 0 ?
                                              $urandom_range(0, 2) : $urandom_range(3, 8)));
      if ($urandom_range(0, 4) == 0) begin
        queue_frame_items($urandom_range(1, items_left_in_frame() - 1), 1'b1);
        wait_idle();
        if ($urandom_range(0, 1) == 0)
          set_size_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, 16)));
        else
          set_size_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 10)));
        midframe_changes++;
      end
      queue_frame_items(items_left_in_frame(), 1'b1);
      wait_idle();
    end

    $display("covered %0d frames, %0d requests, %0d filtered pixels (%0d not compared:",
             frames_done, items_accepted, results_seen, results_unchecked);
    $display("  neighborhood from never-written rows); %0d size writes, %0d mid-frame",
             reg_writes, midframe_changes);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
